### src/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg - shared definitions for the matrix key debouncer
// Widths, reset constants and the scan result type used by lanes and merge.
// ----------------------------------------------------------------------------
package mkd_pkg;

    // Keys carried by one scan word, fixed by the port widths
    localparam int MAX_KEYS = 16;
    // Holdoff counter width
    localparam int HOLD_W = 4;

    localparam int ROWS_DEFAULT = 4;
    localparam int COLS_DEFAULT = 4;

    localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 4'd10;

    // Per-scan result gathered from all lanes
    typedef struct packed {
        logic [MAX_KEYS-1:0] key_state;
        logic [MAX_KEYS-1:0] changed_keys;
    } scan_result_t;

endpackage

### src/matrix_key_debouncer.sv
// ----------------------------------------------------------------------------
// matrix_key_debouncer - keypad debouncer, two-sample agreement with holdoff
// One lane per key, a merge stage and a two-entry output buffer.
// ----------------------------------------------------------------------------
// Each accepted word is one scan frame of raw key samples (bit row*COLS+col,
// 1 = pressed). A key only changes its debounced state when its two most
// recent accepted samples agree, and after a change it ignores the next
// holdoff_scans frames. All keys update in the same cycle in parallel
// lanes, so while in_ready is high the block takes one word per clock,
// and gives one result word per input word in the cycle after acceptance
// at the earliest. in_ready drops only when both entries of the output
// buffer hold words that the consumer has not yet taken. Keys above
// ROWS*COLS (capped at 16) do not exist: their sample bits are ignored
// and their state and change bits read 0. Write holdoff_scans through
// cfg_wr_en and cfg_wr_data only while no word is in flight; reset value is 10.
// ----------------------------------------------------------------------------
module matrix_key_debouncer #(
    parameter int ROWS = mkd_pkg::ROWS_DEFAULT,
    parameter int COLS = mkd_pkg::COLS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mkd_pkg::HOLD_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mkd_pkg::MAX_KEYS-1:0]  key_samples,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mkd_pkg::MAX_KEYS-1:0]  key_state,
    output logic                          any_changed,
    output logic [mkd_pkg::MAX_KEYS-1:0]  changed_keys
);

    // Lanes actually built: the matrix size, capped at the word width
    localparam int KEY_COUNT = (ROWS * COLS > mkd_pkg::MAX_KEYS) ?
                               mkd_pkg::MAX_KEYS : ROWS * COLS;

    logic [mkd_pkg::HOLD_W-1:0]   holdoff_scans_reg;
    logic                         sel_b_reg;
    logic                         accept;
    logic [mkd_pkg::MAX_KEYS-1:0] state_vec;
    logic [mkd_pkg::MAX_KEYS-1:0] changed_vec;
    mkd_pkg::scan_result_t        lane_res;

    assign accept = in_valid && in_ready;

    // Holdoff reload count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_scans_reg <= mkd_pkg::HOLDOFF_RESET;
        end
        else if (cfg_wr_en)
        begin
            holdoff_scans_reg <= cfg_wr_data;
        end
    end

    // Buffer select: toggle once per accepted frame, buffer a first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_b_reg <= 1'b0;
        end
        else if (accept)
        begin
            sel_b_reg <= ~sel_b_reg;
        end
    end

    // One debounce lane per existing key; missing keys tie off to 0
    for (genvar k = 0; k < mkd_pkg::MAX_KEYS; k++)
    begin : g_key
        if (k < KEY_COUNT)
        begin : g_lane
            mkd_lane u_lane (
                .clk           (clk),
                .rst_n         (rst_n),
                .step          (accept),
                .sel_b         (sel_b_reg),
                .sample        (key_samples[k]),
                .holdoff_scans (holdoff_scans_reg),
                .state_next    (state_vec[k]),
                .changed       (changed_vec[k])
            );
        end
        else
        begin : g_none
            assign state_vec[k]   = 1'b0;
            assign changed_vec[k] = 1'b0;
        end
    end

    assign lane_res.key_state    = state_vec;
    assign lane_res.changed_keys = changed_vec;

    // Merge lane results and hold them for the consumer
    mkd_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .lane_res     (lane_res),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .key_state    (key_state),
        .any_changed  (any_changed),
        .changed_keys (changed_keys)
    );

endmodule

### src/mkd_lane.sv
// ----------------------------------------------------------------------------
// mkd_lane - debounce core for one key
// Holdoff counter, two alternating sample bits and the debounced state bit.
// ----------------------------------------------------------------------------
module mkd_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic                           sel_b,
    input  logic                           sample,
    input  logic [mkd_pkg::HOLD_W-1:0]     holdoff_scans,
    output logic                           state_next,
    output logic                           changed
);

    logic [mkd_pkg::HOLD_W-1:0] hold_reg;
    logic [mkd_pkg::HOLD_W-1:0] hold_next;
    logic                       buf_a_reg;
    logic                       buf_a_next;
    logic                       buf_b_reg;
    logic                       buf_b_next;
    logic                       state_reg;
    logic                       take;

    always_comb
    begin
        // ignore the sample while held off
        take       = (hold_reg == '0);
        buf_a_next = (take && !sel_b) ? sample : buf_a_reg;
        buf_b_next = (take &&  sel_b) ? sample : buf_b_reg;
        changed    = (buf_a_next == buf_b_next) && (buf_a_next != state_reg);
        state_next = state_reg ^ changed;
        if (changed)
        begin
            hold_next = holdoff_scans;
        end
        else if (!take)
        begin
            hold_next = hold_reg - mkd_pkg::HOLD_W'(1);
        end
        else
        begin
            hold_next = hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg  <= '0;
            buf_a_reg <= 1'b0;
            buf_b_reg <= 1'b0;
            state_reg <= 1'b0;
        end
        else if (step)
        begin
            hold_reg  <= hold_next;
            buf_a_reg <= buf_a_next;
            buf_b_reg <= buf_b_next;
            state_reg <= state_next;
        end
    end

endmodule

### src/mkd_merge.sv
// ----------------------------------------------------------------------------
// mkd_merge - merge lane results and buffer the output word
// Reduce the change mask to one flag; two-entry output buffer (main + skid).
// ----------------------------------------------------------------------------
module mkd_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  mkd_pkg::scan_result_t         lane_res,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mkd_pkg::MAX_KEYS-1:0]  key_state,
    output logic                          any_changed,
    output logic [mkd_pkg::MAX_KEYS-1:0]  changed_keys
);

    mkd_pkg::scan_result_t main_reg;
    mkd_pkg::scan_result_t main_next;
    mkd_pkg::scan_result_t skid_reg;
    mkd_pkg::scan_result_t skid_next;
    logic                  main_any_reg;
    logic                  main_any_next;
    logic                  skid_any_reg;
    logic                  skid_any_next;
    logic                  main_valid_reg;
    logic                  main_valid_next;
    logic                  skid_valid_reg;
    logic                  skid_valid_next;
    logic                  push;
    logic                  pop;
    logic                  new_any;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = main_valid_reg && out_ready;
    assign new_any  = |lane_res.changed_keys;

    always_comb
    begin
        main_next       = main_reg;
        main_any_next   = main_any_reg;
        main_valid_next = main_valid_reg;
        skid_next       = skid_reg;
        skid_any_next   = skid_any_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            // advance skid into main, else refill from the incoming word
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_any_next   = skid_any_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next     = lane_res;
                main_any_next = new_any;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = lane_res;
                main_any_next   = new_any;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = lane_res;
                skid_any_next   = new_any;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg     <= main_next;
        main_any_reg <= main_any_next;
        skid_reg     <= skid_next;
        skid_any_reg <= skid_any_next;
    end

    assign out_valid    = main_valid_reg;
    assign key_state    = main_reg.key_state;
    assign changed_keys = main_reg.changed_keys;
    assign any_changed  = main_any_reg;

endmodule

### src/mkd_checker.sv
// ----------------------------------------------------------------------------
// mkd_checker - port-level checks for the matrix key debouncer
// Watches the top level's ports only; attached by bind below.
// ----------------------------------------------------------------------------
module mkd_checker #(
    parameter int ROWS = mkd_pkg::ROWS_DEFAULT,
    parameter int COLS = mkd_pkg::COLS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [mkd_pkg::MAX_KEYS-1:0]  key_state,
    input  logic                          any_changed,
    input  logic [mkd_pkg::MAX_KEYS-1:0]  changed_keys
);

    localparam int KEY_COUNT = (ROWS * COLS > mkd_pkg::MAX_KEYS) ?
                               mkd_pkg::MAX_KEYS : ROWS * COLS;
    localparam logic [mkd_pkg::MAX_KEYS-1:0] KEY_MASK =
        (KEY_COUNT >= mkd_pkg::MAX_KEYS) ? {mkd_pkg::MAX_KEYS{1'b1}} :
        mkd_pkg::MAX_KEYS'((32'd1 << KEY_COUNT) - 32'd1);

    logic [mkd_pkg::MAX_KEYS-1:0] last_state_reg;

    // Track the debounced state of the last delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_state_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            last_state_reg <= key_state;
        end
    end

    // Each delivered word moves exactly the keys it flags as changed
    a_state_follows_changes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |-> ((key_state ^ last_state_reg) == changed_keys))
        else $error("key_state does not follow changed_keys");

    a_flag_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (any_changed == (changed_keys != '0)))
        else $error("any_changed disagrees with changed_keys");

    a_no_phantom_keys: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((key_state | changed_keys) & ~KEY_MASK) == '0))
        else $error("bits set for keys outside the matrix");

    // Input stalls only while an output word is waiting
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(key_state)
            && $stable(changed_keys) && $stable(any_changed)))
        else $error("output word dropped or changed while stalled");

endmodule

bind matrix_key_debouncer mkd_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_mkd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .key_state    (key_state),
    .any_changed  (any_changed),
    .changed_keys (changed_keys)
);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the matrix key debouncer
// Scan words go in over a valid/ready channel, and a local model of the
// debounce logic predicts each result word. Results are checked in order,
// field by field, under several idle and stall mixes and several holdoff
// settings. One stretch holds the consumer off long enough to fill the block.
// ----------------------------------------------------------------------------
module tb_top;

    import mkd_pkg::*;

    localparam int TB_ROWS = 4;
    localparam int TB_COLS = 4;
    // Keys that exist in the matrix, capped at the width of a scan word
    localparam int NUM_KEYS = (TB_ROWS * TB_COLS > MAX_KEYS) ? MAX_KEYS : TB_ROWS * TB_COLS;
    localparam logic [MAX_KEYS-1:0] KEY_MASK =
        (NUM_KEYS >= MAX_KEYS) ? '1 : ((16'd1 << NUM_KEYS) - 16'd1);
    // Cycles to let pass once the last result word is in, before a register write
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 140;

    // One result word as it leaves the block
    typedef struct packed {
        logic [MAX_KEYS-1:0] key_state;
        logic                any_changed;
        logic [MAX_KEYS-1:0] changed_keys;
    } scan_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [HOLD_W-1:0]   cfg_wr_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [MAX_KEYS-1:0] key_samples = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [MAX_KEYS-1:0] key_state;
    logic                any_changed;
    logic [MAX_KEYS-1:0] changed_keys;

    // Debounce model state, mirrors the block after reset
    logic [MAX_KEYS-1:0] buf_a = '0;
    logic [MAX_KEYS-1:0] buf_b = '0;
    logic                buf_sel = 1'b0;
    logic [MAX_KEYS-1:0] debounced = '0;
    logic [HOLD_W-1:0]   holdoff_left [MAX_KEYS];
    logic [HOLD_W-1:0]   holdoff_setting = HOLDOFF_RESET;

    // Result words predicted but not yet seen at the output
    scan_word_t pending_scans [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int ready_hold_cycles = 0;
    int error_count = 0;
    // Slowly changing "true" key pattern that the random scans bounce around
    logic [MAX_KEYS-1:0] pressed_keys = '0;

    matrix_key_debouncer #(
        .ROWS(TB_ROWS),
        .COLS(TB_COLS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key_samples (key_samples),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .key_state   (key_state),
        .any_changed (any_changed),
        .changed_keys(changed_keys)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int k = 0; k < MAX_KEYS; k++)
            holdoff_left[k] = '0;
    end

    // Advance the debounce model by one scan word and return the result word.
    function automatic scan_word_t debounce_scan(input logic [MAX_KEYS-1:0] raw);
        logic [MAX_KEYS-1:0] samples;
        logic [MAX_KEYS-1:0] take;
        logic [MAX_KEYS-1:0] agree;
        logic [MAX_KEYS-1:0] flips;
        scan_word_t          res;
        samples = raw & KEY_MASK;
        take = '0;
        // Keys still in holdoff count down and drop their sample
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (holdoff_left[k] != '0)
                holdoff_left[k] = holdoff_left[k] - 1'b1;
            else
                take[k] = 1'b1;
        end
        if (buf_sel)
            buf_b = (buf_b & ~take) | (samples & take);
        else
            buf_a = (buf_a & ~take) | (samples & take);
        buf_sel = ~buf_sel;
        // A key moves only where both sample buffers hold the same value
        agree = ~(buf_a ^ buf_b) & KEY_MASK;
        flips = (buf_a ^ debounced) & agree;
        debounced = debounced ^ flips;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            if (flips[k])
                holdoff_left[k] = holdoff_setting;
        end
        res.key_state = debounced;
        res.any_changed = (flips != '0);
        res.changed_keys = flips;
        return res;
    endfunction

    // Offer one scan word, with random idle cycles ahead of it, and record
    // its prediction at the edge where it is taken.
    task automatic send_scan(input logic [MAX_KEYS-1:0] raw);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            key_samples <= MAX_KEYS'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        key_samples <= raw;
        do
            @(posedge clk);
        while (!in_ready);
        pending_scans.push_back(debounce_scan(raw));
    endtask

    // Drop valid and wait until every predicted word has come out, then
    // let the block settle.
    task automatic drain_scans();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write holdoff_scans; drains the block first.
    task automatic write_holdoff(input logic [HOLD_W-1:0] scans);
        drain_scans();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= scans;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= HOLD_W'($urandom);
        holdoff_setting = scans;
    endtask

    // Pick the next random scan: mostly a steady pattern with the odd
    // bouncing contact, sometimes plain noise.
    function automatic logic [MAX_KEYS-1:0] next_random_scan();
        logic [MAX_KEYS-1:0] bounce;
        bounce = '0;
        if ($urandom_range(99) < 70)
        begin
            // Move the pressed set now and then, hold it otherwise
            if ($urandom_range(7) == 0)
                pressed_keys = MAX_KEYS'($urandom);
            if ($urandom_range(3) == 0)
                bounce[$urandom_range(MAX_KEYS-1)] = 1'b1;
            return pressed_keys ^ bounce;
        end
        return MAX_KEYS'($urandom);
    endfunction

    // Power-up behavior at the reset holdoff of 10: the first scan cannot
    // raise a key, the second one can, and then holdoff masks a release.
    task automatic test_power_up();
        send_scan(16'hFFFF);
        send_scan(16'hFFFF);
        repeat (3) send_scan(16'h0000);
    endtask

    // Holdoff at both ends of its range, plus single keys at the matrix edges.
    task automatic test_holdoff_extremes();
        write_holdoff(4'd0);
        send_scan(16'h0000);
        send_scan(16'h0000);
        send_scan(16'hA5A5);
        send_scan(16'h5A5A);
        send_scan(16'h5A5A);
        send_scan(16'hFFFF);
        send_scan(16'h0000);
        send_scan(16'h0001);
        send_scan(16'h0001);
        send_scan(16'h8000);
        send_scan(16'h8000);
        write_holdoff(4'd15);
        send_scan(16'hFFFF);
        send_scan(16'hFFFF);
        repeat (3) send_scan(16'h0000);
    endtask

    // Random scans under one idle and stall mix and one holdoff setting.
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic [HOLD_W-1:0] scans);
        write_holdoff(scans);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (ITEMS_PER_PHASE) send_scan(next_random_scan());
    endtask

    // Hold the consumer off for a long stretch while scans keep coming, so
    // the output buffer fills and in_ready drops.
    task automatic test_output_backpressure();
        write_holdoff(HOLD_W'($urandom_range(1, 14)));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        ready_hold_cycles = 60;
        repeat (30) send_scan(next_random_scan());
    endtask

    // Consumer side: stall at random, or hold off for a counted stretch.
    always @(negedge clk)
    begin
        if (ready_hold_cycles > 0)
        begin
            out_ready <= 1'b0;
            ready_hold_cycles = ready_hold_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every result word taken with the oldest prediction.
    always @(posedge clk)
    begin
        scan_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_scans.size() == 0)
            begin
                $error("result word with nothing predicted: key_state %h changed_keys %h",
                       key_state, changed_keys);
                error_count++;
            end
            else
            begin
                want = pending_scans.pop_front();
                if (key_state !== want.key_state)
                begin
                    $error("key_state mismatch: expected %h, actual %h",
                           want.key_state, key_state);
                    error_count++;
                end
                if (any_changed !== want.any_changed)
                begin
                    $error("any_changed mismatch: expected %b, actual %b",
                           want.any_changed, any_changed);
                    error_count++;
                end
                if (changed_keys !== want.changed_keys)
                begin
                    $error("changed_keys mismatch: expected %h, actual %h",
                           want.changed_keys, changed_keys);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        // Hold reset, then release it away from the rising edge
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_up();
        test_holdoff_extremes();
        test_random_phase(0, 0, 4'd0);
        test_random_phase(86, 0, 4'd15);
        test_random_phase(0, 86, HOLD_W'($urandom_range(1, 14)));
        test_random_phase(18, 18, 4'd10);
        test_output_backpressure();

        drain_scans();
        if (pending_scans.size() != 0)
        begin
            $error("%0d predicted result words never came out", pending_scans.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Hard stop: far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
